>>> design/mh_pkg.sv
package mh_pkg;

	localparam int ANGLE_STEPS = 16;
	localparam int TABLE_LEN   = 24;
	localparam int STEP_W      = $clog2(TABLE_LEN);
	localparam int MAG_W       = 16;
	localparam int VEC_SHIFT   = 20;
	localparam int VEC_W       = MAG_W + VEC_SHIFT + 2;
	localparam int ATAN_W      = 22;
	localparam int ANG_W       = 26;
	localparam int OUT_SHIFT   = 10;
	localparam int HEADING_W   = 15;

	localparam logic [HEADING_W-1:0] HEADING_MAX = 15'd23039;

	localparam logic signed [ANG_W-1:0] DEG_90  = 26'sd5898240;
	localparam logic signed [ANG_W-1:0] DEG_180 = 26'sd11796480;
	localparam logic signed [ANG_W-1:0] DEG_360 = 26'sd23592960;

	typedef logic signed [VEC_W-1:0] vec_word_t;
	typedef logic signed [ANG_W-1:0] ang_t;

	typedef struct packed {
		vec_word_t x;
		vec_word_t y;
		ang_t      z;
	} cordic_t;

	typedef struct packed {
		logic [MAG_W-1:0] x_mag;
		logic [MAG_W-1:0] y_mag;
		logic             x_neg;
		logic             y_neg;
	} axis_t;

	// atan(2^-i) in units of 2^-16 degree
	function automatic logic [ATAN_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
		logic [ATAN_W-1:0] r;
		case (idx)
			5'd0:    r = 22'd2949120;
			5'd1:    r = 22'd1740967;
			5'd2:    r = 22'd919879;
			5'd3:    r = 22'd466945;
			5'd4:    r = 22'd234379;
			5'd5:    r = 22'd117304;
			5'd6:    r = 22'd58666;
			5'd7:    r = 22'd29335;
			5'd8:    r = 22'd14668;
			5'd9:    r = 22'd7334;
			5'd10:   r = 22'd3667;
			5'd11:   r = 22'd1833;
			5'd12:   r = 22'd917;
			5'd13:   r = 22'd458;
			5'd14:   r = 22'd229;
			5'd15:   r = 22'd115;
			5'd16:   r = 22'd57;
			5'd17:   r = 22'd29;
			5'd18:   r = 22'd14;
			5'd19:   r = 22'd7;
			5'd20:   r = 22'd4;
			5'd21:   r = 22'd2;
			5'd22:   r = 22'd1;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

	// arithmetic right shift that truncates toward zero
	function automatic vec_word_t shr_trunc(input vec_word_t v, input logic [STEP_W-1:0] s);
		logic [VEC_W-1:0] mag;
		logic [VEC_W-1:0] sh;
		mag = v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
		sh  = mag >> s;
		return v[VEC_W-1] ? -vec_word_t'(sh) : vec_word_t'(sh);
	endfunction

endpackage

>>> design/mh_prep.sv
module mh_prep
	import mh_pkg::*;
(
	input  logic [7:0] x_high_byte,
	input  logic [7:0] x_low_byte,
	input  logic [7:0] y_high_byte,
	input  logic [7:0] y_low_byte,
	output cordic_t    vec,
	output axis_t      side
);

	logic [MAG_W-1:0] xv;
	logic [MAG_W-1:0] yv;
	logic [MAG_W-1:0] ax;
	logic [MAG_W-1:0] ay;

	always_comb begin
		xv = {x_high_byte, x_low_byte};
		yv = {y_high_byte, y_low_byte};
		ax = xv[MAG_W-1] ? (~xv + 1'b1) : xv;
		ay = yv[MAG_W-1] ? (~yv + 1'b1) : yv;

		side.x_mag = ax;
		side.y_mag = ay;
		side.x_neg = xv[MAG_W-1];
		side.y_neg = yv[MAG_W-1];

		vec.x = vec_word_t'({2'b00, ax, {VEC_SHIFT{1'b0}}});
		vec.y = vec_word_t'({2'b00, ay, {VEC_SHIFT{1'b0}}});
		vec.z = '0;
	end

endmodule

>>> design/mh_cell.sv
module mh_cell
	import mh_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [STEP_W-1:0] step_idx,
	input  logic              up_valid,
	output logic              up_stall,
	input  cordic_t           up_vec,
	input  axis_t             up_side,
	output logic              dn_valid,
	input  logic              dn_stall,
	output cordic_t           dn_vec,
	output axis_t             dn_side
);

	logic      valid_q;
	cordic_t   vec_q;
	axis_t     side_q;
	cordic_t   vec_nxt;
	vec_word_t xs;
	vec_word_t ys;
	ang_t      step_ang;
	logic      load;

	assign load     = !valid_q || !dn_stall;
	assign up_stall = !load;

	always_comb begin
		xs       = shr_trunc(up_vec.x, step_idx);
		ys       = shr_trunc(up_vec.y, step_idx);
		step_ang = ang_t'(atan_entry(step_idx));
		if (!up_vec.y[VEC_W-1]) begin
			vec_nxt.x = up_vec.x + ys;
			vec_nxt.y = up_vec.y - xs;
			vec_nxt.z = up_vec.z + step_ang;
		end else begin
			vec_nxt.x = up_vec.x - ys;
			vec_nxt.y = up_vec.y + xs;
			vec_nxt.z = up_vec.z - step_ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && up_valid) begin
			vec_q  <= vec_nxt;
			side_q <= up_side;
		end
	end

	assign dn_valid = valid_q;
	assign dn_vec   = vec_q;
	assign dn_side  = side_q;

endmodule

>>> design/mh_post.sv
module mh_post
	import mh_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	output logic                 up_stall,
	input  cordic_t              up_vec,
	input  axis_t                up_side,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [HEADING_W-1:0] heading,
	output logic [MAG_W-1:0]     x_magnitude,
	output logic                 x_negative,
	output logic [MAG_W-1:0]     y_magnitude,
	output logic                 y_negative,
	output logic                 no_field
);

	logic                 valid_q;
	logic [HEADING_W-1:0] heading_q;
	axis_t                side_q;
	logic                 none_q;
	logic                 load;
	logic                 none;
	ang_t                 theta;
	ang_t                 full;
	logic [ANG_W-1:0]     shifted;
	logic [HEADING_W-1:0] head_nxt;

	assign load     = !valid_q || !out_stall;
	assign up_stall = !load;

	always_comb begin
		none = (up_side.x_mag == '0) && (up_side.y_mag == '0);
		if (up_side.y_mag == '0) begin
			theta = '0;
		end else if (up_side.x_mag == '0) begin
			theta = DEG_90;
		end else if (up_vec.z < 0) begin
			theta = '0;
		end else if (up_vec.z > DEG_90) begin
			theta = DEG_90;
		end else begin
			theta = up_vec.z;
		end

		case ({up_side.x_neg, up_side.y_neg})
			2'b00:   full = theta;
			2'b10:   full = DEG_180 - theta;
			2'b11:   full = DEG_180 + theta;
			default: full = DEG_360 - theta;
		endcase

		if (full < 0) begin
			full = '0;
		end
		shifted = ANG_W'(full) >> OUT_SHIFT;
		if (none) begin
			head_nxt = '0;
		end else if (shifted > ANG_W'(HEADING_MAX)) begin
			head_nxt = HEADING_MAX;
		end else begin
			head_nxt = shifted[HEADING_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && up_valid) begin
			heading_q <= head_nxt;
			side_q    <= up_side;
			none_q    <= none;
		end
	end

	assign out_valid   = valid_q;
	assign heading     = heading_q;
	assign x_magnitude = side_q.x_mag;
	assign x_negative  = side_q.x_neg;
	assign y_magnitude = side_q.y_mag;
	assign y_negative  = side_q.y_neg;
	assign no_field    = none_q;

endmodule

>>> design/magnetometer_heading_top.sv
// Compass heading from magnetometer X/Y register bytes. Each word gives the high
// and low bytes of both axes; the result word gives atan2(Y,X) over 0..360 degrees
// in 1/64 degree steps, plus sign and magnitude of each axis and a no-field flag.
// The angle comes from a row of ANGLE_STEPS CORDIC cells, one iteration and one
// register per cell, followed by an output register. A new word is taken every
// cycle while in_stall is low. Each cell holds its word while the next one is full
// and stalled, so bubbles close up; in_stall rises only when every stage holds a
// word and out_stall is high.
module magnetometer_heading_top
	import mh_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           x_high_byte,
	input  logic [7:0]           x_low_byte,
	input  logic [7:0]           y_high_byte,
	input  logic [7:0]           y_low_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [HEADING_W-1:0] heading,
	output logic [MAG_W-1:0]     x_magnitude,
	output logic                 x_negative,
	output logic [MAG_W-1:0]     y_magnitude,
	output logic                 y_negative,
	output logic                 no_field
);

	logic    valid_c [0:ANGLE_STEPS];
	logic    stall_c [0:ANGLE_STEPS];
	cordic_t vec_c   [0:ANGLE_STEPS];
	axis_t   side_c  [0:ANGLE_STEPS];

	mh_prep u_prep (
		.x_high_byte (x_high_byte),
		.x_low_byte  (x_low_byte),
		.y_high_byte (y_high_byte),
		.y_low_byte  (y_low_byte),
		.vec         (vec_c[0]),
		.side        (side_c[0])
	);

	assign valid_c[0] = in_valid;
	assign in_stall   = stall_c[0];

	for (genvar i = 0; i < ANGLE_STEPS; i++) begin : g_cell
		mh_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.step_idx (STEP_W'(i)),
			.up_valid (valid_c[i]),
			.up_stall (stall_c[i]),
			.up_vec   (vec_c[i]),
			.up_side  (side_c[i]),
			.dn_valid (valid_c[i+1]),
			.dn_stall (stall_c[i+1]),
			.dn_vec   (vec_c[i+1]),
			.dn_side  (side_c[i+1])
		);
	end

	mh_post u_post (
		.clk         (clk),
		.arst_n      (arst_n),
		.up_valid    (valid_c[ANGLE_STEPS]),
		.up_stall    (stall_c[ANGLE_STEPS]),
		.up_vec      (vec_c[ANGLE_STEPS]),
		.up_side     (side_c[ANGLE_STEPS]),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.heading     (heading),
		.x_magnitude (x_magnitude),
		.x_negative  (x_negative),
		.y_magnitude (y_magnitude),
		.y_negative  (y_negative),
		.no_field    (no_field)
	);

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output stage can take a word");

	a_no_field: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && no_field) |-> (heading == '0 && x_magnitude == '0 && y_magnitude == '0))
		else $error("no_field word with nonzero heading or magnitude");

	a_heading_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (heading <= HEADING_MAX))
		else $error("heading out of range");

	a_first_quad: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !x_negative && !y_negative) |-> (heading <= HEADING_W'(90 * 64)))
		else $error("first-quadrant heading above 90 degrees");

endmodule
